>>> rtl/vtesc_pkg.sv
// Shared types, byte codes and helper functions of the VT escape sequence parser.
package vtesc_pkg;

    // Parser states. The encoding is the state code reported with an error.
    typedef enum logic [2:0] {
        PS_GROUND = 3'd0,
        PS_ESC    = 3'd1,
        PS_ENTRY  = 3'd2,
        PS_PARAM  = 3'd3,
        PS_INTER  = 3'd4,
        PS_DLE    = 3'd5,
        PS_TEXT   = 3'd6
    } parse_state_t;

    // Text frame read-out sequencer.
    typedef enum logic [1:0] {
        BURST_IDLE,
        BURST_READ,
        BURST_SEND,
        BURST_END
    } burst_t;

    // Result kinds.
    localparam logic [2:0] KIND_CHAR     = 3'd0;
    localparam logic [2:0] KIND_ARROW    = 3'd1;
    localparam logic [2:0] KIND_CSI      = 3'd2;
    localparam logic [2:0] KIND_ERROR    = 3'd3;
    localparam logic [2:0] KIND_TEXT     = 3'd4;
    localparam logic [2:0] KIND_TEXT_END = 3'd5;

    // Byte codes.
    localparam logic [7:0] CH_ESC      = 8'h1B;
    localparam logic [7:0] CH_CSI      = 8'h9B;
    localparam logic [7:0] CH_DLE      = 8'h10;
    localparam logic [7:0] CH_STX      = 8'h02;
    localparam logic [7:0] CH_ETX      = 8'h03;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_SEMI     = 8'h3B;
    localparam logic [7:0] CH_DIGIT_LO = 8'h30;
    localparam logic [7:0] CH_DIGIT_HI = 8'h39;
    localparam logic [7:0] CH_LEAD_LO  = 8'h3C;
    localparam logic [7:0] CH_LEAD_HI  = 8'h3F;
    localparam logic [7:0] CH_INTER_LO = 8'h20;
    localparam logic [7:0] CH_INTER_HI = 8'h2F;
    localparam logic [7:0] CH_FINAL_LO = 8'h40;
    localparam logic [7:0] CH_FINAL_HI = 8'h7E;
    localparam logic [7:0] CH_DEL      = 8'h7F;
    localparam logic [7:0] CH_ARROW_LO = 8'h41;
    localparam logic [7:0] CH_ARROW_HI = 8'h44;

    // One result item as it sits in the output register.
    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  value;
        logic [15:0] param_first;
        logic [15:0] param_second;
        logic [7:0]  param_count;
        logic [3:0]  inter_count;
        logic [5:0]  leader;
        logic [2:0]  state_code;
        logic        overflow;
        logic        last;
    } result_t;

    // Appends one decimal digit to a parameter, saturating at 65535.
    function automatic logic [15:0] acc_digit(input logic [15:0] p, input logic [7:0] c);
        logic [19:0] v;
        v = {1'b0, p, 3'b000} + {3'b000, p, 1'b0} + {16'd0, c[3:0]};
        return (v > 20'h0FFFF) ? 16'hFFFF : v[15:0];
    endfunction

endpackage

>>> rtl/vtesc_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module vtesc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/vt_escape_sequence_parser_core.sv
// Top level of the VT escape sequence parser: byte decoder, text buffer and result register.
//
// Usage. Received terminal bytes enter on the input channel (in_valid, in_ready, rx_byte),
// one byte per transfer. Results leave on the output channel (out_valid, out_ready and one
// port per field); last marks the final result caused by an input byte. Plain bytes pass
// through as characters, ESC and 0x9B open escape and CSI parsing, and a CSI final gives an
// arrow result for A to D or a CSI report otherwise. Bad bytes give an error result.
// DLE STX opens a text frame whose bytes are written to the text RAM; DLE ETX reads the
// frame back out as text-byte results followed by one text-end result.
// A byte that causes a single result has it in the output register the cycle after its
// transfer. A new byte is taken in every cycle while the output register is empty or being
// drained and no frame is being read back.
// A DLE ETX reads the frame back byte by byte: each stored byte is a RAM read followed by
// a load of the output register from the read data; in_ready is low for that read-out.
// If the receiver stalls, the result waits in the output register and in_ready drops until
// it is taken. Reset returns the parser to ground with an empty frame; the text RAM is not
// cleared, because only entries below the frame length are ever read back.
module vt_escape_sequence_parser_core #(
    parameter int TEXT_DEPTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  kind,
    output logic [7:0]  value,
    output logic [15:0] param_first,
    output logic [15:0] param_second,
    output logic [7:0]  param_count,
    output logic [3:0]  inter_count,
    output logic [5:0]  leader,
    output logic [2:0]  state_code,
    output logic        overflow,
    output logic        last
);
    import vtesc_pkg::*;

    localparam int AW = (TEXT_DEPTH > 1) ? $clog2(TEXT_DEPTH) : 1;
    localparam int LW = $clog2(TEXT_DEPTH + 1);
    localparam logic [LW-1:0] DEPTH_L = LW'(TEXT_DEPTH);

    // Parser state.
    parse_state_t  pst_reg, pst_next;
    logic          in_text_reg, in_text_next;
    logic [15:0]   p1_reg, p1_next;
    logic [15:0]   p2_reg, p2_next;
    logic [7:0]    pcnt_reg, pcnt_next;
    logic [3:0]    icnt_reg, icnt_next;
    logic [5:0]    lead_reg, lead_next;
    logic [LW-1:0] len_reg, len_next;
    logic          ovf_reg, ovf_next;

    // Read-out sequencer.
    burst_t        burst_reg, burst_next;
    logic [LW-1:0] idx_reg, idx_next;

    // Output register.
    logic          out_valid_reg, out_valid_next;
    result_t       res_reg, res_next;

    // Text RAM.
    logic          ram_we;
    logic          ram_re;
    logic [7:0]    ram_rdata;

    logic          accept;
    logic          slot_free;
    logic          dec_emit;
    logic          burst_start;
    logic          burst_load;
    result_t       dec_res;
    result_t       burst_res;

    logic is_digit, is_lead, is_inter, is_final_wide, is_final, is_arrow;
    logic do_err, do_final, do_char;
    logic [7:0] pcnt_inc;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (burst_reg == BURST_IDLE) && slot_free;
    assign accept    = in_valid && in_ready;

    assign is_digit      = (rx_byte >= CH_DIGIT_LO) && (rx_byte <= CH_DIGIT_HI);
    assign is_lead       = (rx_byte >= CH_LEAD_LO) && (rx_byte <= CH_LEAD_HI);
    assign is_inter      = (rx_byte >= CH_INTER_LO) && (rx_byte <= CH_INTER_HI);
    assign is_final_wide = (rx_byte >= CH_FINAL_LO) && (rx_byte <= CH_DEL);
    assign is_final      = (rx_byte >= CH_FINAL_LO) && (rx_byte <= CH_FINAL_HI);
    assign is_arrow      = (rx_byte >= CH_ARROW_LO) && (rx_byte <= CH_ARROW_HI);
    assign pcnt_inc      = (pcnt_reg == 8'hFF) ? pcnt_reg : pcnt_reg + 8'd1;

    // Byte decoder: next parser state and the single result a byte may cause.
    always_comb
    begin
        pst_next     = pst_reg;
        in_text_next = in_text_reg;
        p1_next      = p1_reg;
        p2_next      = p2_reg;
        pcnt_next    = pcnt_reg;
        icnt_next    = icnt_reg;
        lead_next    = lead_reg;
        len_next     = len_reg;
        ovf_next     = ovf_reg;
        do_err       = 1'b0;
        do_final     = 1'b0;
        do_char      = 1'b0;
        burst_start  = 1'b0;
        ram_we       = 1'b0;
        dec_res      = '0;

        unique case (pst_reg)
            PS_ESC:
            begin
                if (rx_byte == CH_LBRACKET)
                begin
                    pst_next  = PS_ENTRY;
                    p1_next   = '0;
                    p2_next   = '0;
                    pcnt_next = '0;
                    icnt_next = '0;
                    lead_next = '0;
                end
                else if (rx_byte >= CH_DIGIT_LO && rx_byte <= CH_DEL)
                begin
                    pst_next = PS_GROUND;
                end
                else
                begin
                    do_err = 1'b1;
                end
            end
            PS_ENTRY:
            begin
                if (is_lead)
                begin
                    lead_next = rx_byte[5:0];
                    pcnt_next = pcnt_inc;
                    pst_next  = PS_PARAM;
                end
                else if (is_digit)
                begin
                    pst_next  = PS_PARAM;
                    pcnt_next = pcnt_inc;
                    if (pcnt_inc == 8'd1)
                    begin
                        p1_next = acc_digit(p1_reg, rx_byte);
                    end
                    else if (pcnt_inc == 8'd2)
                    begin
                        p2_next = acc_digit(p2_reg, rx_byte);
                    end
                end
                else if (is_inter)
                begin
                    pst_next  = PS_INTER;
                    icnt_next = (icnt_reg == 4'hF) ? icnt_reg : icnt_reg + 4'd1;
                end
                else if (is_final_wide)
                begin
                    do_final = 1'b1;
                end
                else
                begin
                    do_err = 1'b1;
                end
            end
            PS_PARAM:
            begin
                if (is_digit)
                begin
                    if (pcnt_reg == 8'd1)
                    begin
                        p1_next = acc_digit(p1_reg, rx_byte);
                    end
                    else if (pcnt_reg == 8'd2)
                    begin
                        p2_next = acc_digit(p2_reg, rx_byte);
                    end
                end
                else if (rx_byte == CH_SEMI)
                begin
                    pcnt_next = pcnt_inc;
                end
                else if (is_inter)
                begin
                    pst_next  = PS_INTER;
                    icnt_next = (icnt_reg == 4'hF) ? icnt_reg : icnt_reg + 4'd1;
                end
                else if (is_final)
                begin
                    do_final = 1'b1;
                end
                else
                begin
                    do_err = 1'b1;
                end
            end
            PS_INTER:
            begin
                if (is_inter)
                begin
                    icnt_next = (icnt_reg == 4'hF) ? icnt_reg : icnt_reg + 4'd1;
                end
                else if (is_final)
                begin
                    do_final = 1'b1;
                end
                else
                begin
                    do_err = 1'b1;
                end
            end
            PS_DLE:
            begin
                if (rx_byte == CH_STX && !in_text_reg)
                begin
                    len_next = '0;
                    ovf_next = 1'b0;
                    pst_next = PS_TEXT;
                end
                else if (rx_byte == CH_ETX && in_text_reg)
                begin
                    pst_next    = PS_GROUND;
                    burst_start = 1'b1;
                end
                else
                begin
                    do_err = 1'b1;
                end
            end
            PS_TEXT:
            begin
                if (rx_byte == CH_DLE)
                begin
                    in_text_next = 1'b1;
                    pst_next     = PS_DLE;
                end
                else if (len_reg < DEPTH_L)
                begin
                    ram_we   = 1'b1;
                    len_next = len_reg + LW'(1);
                end
                else
                begin
                    ovf_next = 1'b1;
                end
            end
            default:
            begin
                // Ground, and the unused state code, which behaves as ground.
                if (rx_byte == CH_ESC)
                begin
                    pst_next = PS_ESC;
                end
                else if (rx_byte == CH_CSI)
                begin
                    pst_next  = PS_ENTRY;
                    p1_next   = '0;
                    p2_next   = '0;
                    pcnt_next = '0;
                    icnt_next = '0;
                    lead_next = '0;
                end
                else if (rx_byte == CH_DLE)
                begin
                    in_text_next = 1'b0;
                    pst_next     = PS_DLE;
                end
                else
                begin
                    do_char = 1'b1;
                end
            end
        endcase

        if (do_err)
        begin
            pst_next           = PS_GROUND;
            dec_res.kind       = KIND_ERROR;
            dec_res.value      = rx_byte;
            dec_res.state_code = pst_reg;
        end
        if (do_final)
        begin
            pst_next = PS_GROUND;
            if (pcnt_reg == 8'd0)
            begin
                pcnt_next = 8'd1;
            end
            if (is_arrow)
            begin
                dec_res.kind  = KIND_ARROW;
                dec_res.value = rx_byte - CH_ARROW_LO;
            end
            else
            begin
                dec_res.kind         = KIND_CSI;
                dec_res.value        = rx_byte;
                dec_res.param_first  = p1_reg;
                dec_res.param_second = p2_reg;
                dec_res.param_count  = (pcnt_reg == 8'd0) ? 8'd1 : pcnt_reg;
                dec_res.inter_count  = icnt_reg;
                dec_res.leader       = lead_reg;
            end
        end
        if (do_char)
        begin
            dec_res.kind  = KIND_CHAR;
            dec_res.value = rx_byte;
        end
        dec_res.last = 1'b1;
        dec_emit     = do_err || do_final || do_char;
    end

    // Read-out sequencer: each stored byte is read, then loaded once the output slot is free.
    always_comb
    begin
        burst_next = burst_reg;
        idx_next   = idx_reg;
        ram_re     = 1'b0;
        burst_load = 1'b0;
        burst_res  = '0;

        unique case (burst_reg)
            BURST_IDLE:
            begin
                if (accept && burst_start)
                begin
                    idx_next   = '0;
                    burst_next = (len_reg == '0) ? BURST_END : BURST_READ;
                end
            end
            BURST_READ:
            begin
                ram_re     = 1'b1;
                burst_next = BURST_SEND;
            end
            BURST_SEND:
            begin
                burst_res.kind  = KIND_TEXT;
                burst_res.value = ram_rdata;
                if (slot_free)
                begin
                    burst_load = 1'b1;
                    idx_next   = idx_reg + LW'(1);
                    burst_next = (idx_reg + LW'(1) == len_reg) ? BURST_END : BURST_READ;
                end
            end
            BURST_END:
            begin
                burst_res.kind     = KIND_TEXT_END;
                burst_res.overflow = ovf_reg;
                burst_res.last     = 1'b1;
                if (slot_free)
                begin
                    burst_load = 1'b1;
                    burst_next = BURST_IDLE;
                end
            end
            default:
            begin
                burst_next = BURST_IDLE;
            end
        endcase
    end

    // Output register.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        res_next       = res_reg;
        if (accept && dec_emit)
        begin
            out_valid_next = 1'b1;
            res_next       = dec_res;
        end
        else if (burst_load)
        begin
            out_valid_next = 1'b1;
            res_next       = burst_res;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pst_reg       <= PS_GROUND;
            in_text_reg   <= 1'b0;
            p1_reg        <= '0;
            p2_reg        <= '0;
            pcnt_reg      <= '0;
            icnt_reg      <= '0;
            lead_reg      <= '0;
            len_reg       <= '0;
            ovf_reg       <= 1'b0;
            burst_reg     <= BURST_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                pst_reg     <= pst_next;
                in_text_reg <= in_text_next;
                p1_reg      <= p1_next;
                p2_reg      <= p2_next;
                pcnt_reg    <= pcnt_next;
                icnt_reg    <= icnt_next;
                lead_reg    <= lead_next;
                len_reg     <= len_next;
                ovf_reg     <= ovf_next;
            end
            burst_reg     <= burst_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    vtesc_ram #(
        .WIDTH (8),
        .DEPTH (TEXT_DEPTH)
    ) u_text_ram (
        .clk   (clk),
        .we    (accept && ram_we),
        .waddr (len_reg[AW-1:0]),
        .wdata (rx_byte),
        .re    (ram_re),
        .raddr (idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign out_valid    = out_valid_reg;
    assign kind         = res_reg.kind;
    assign value        = res_reg.value;
    assign param_first  = res_reg.param_first;
    assign param_second = res_reg.param_second;
    assign param_count  = res_reg.param_count;
    assign inter_count  = res_reg.inter_count;
    assign leader       = res_reg.leader;
    assign state_code   = res_reg.state_code;
    assign overflow     = res_reg.overflow;
    assign last         = res_reg.last;

`ifndef NO_ASSERTIONS
    // A frame write never happens while the frame is being read back.
    a_no_write_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && ram_we) |-> (burst_reg == BURST_IDLE))
        else $error("text RAM written during read-out");

    // The frame length never passes the buffer depth.
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= DEPTH_L)
        else $error("text length beyond buffer depth");

    // A RAM read is always followed by the cycle that uses its data.
    a_read_then_send: assert property (@(posedge clk) disable iff (!rst_n)
        (burst_reg == BURST_READ) |=> (burst_reg == BURST_SEND))
        else $error("read-out sequencer skipped its data cycle");

    // No byte is taken while a frame is being read back.
    a_no_accept_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (burst_reg != BURST_IDLE) |-> !in_ready)
        else $error("input accepted during read-out");
`endif

endmodule

>>> sim/tb_vt_escape_sequence_parser_core.sv
// Self-checking testbench for the VT escape sequence parser core, with its own result predictor.
module tb_vt_escape_sequence_parser_core;
    timeunit 1ns;
    timeprecision 1ps;

    import vtesc_pkg::*;

    localparam int TEXT_DEPTH = 32;
    localparam int FRAME_AW = $clog2(TEXT_DEPTH);
    // The limit only serves to catch a hang.
    localparam int CYCLE_LIMIT = 200000;
    // Length of the one long receiver hold-off, and the byte count that triggers it.
    localparam int LONG_HOLD_CYCLES = 200;
    localparam int LONG_HOLD_AFTER = 70;
    // Cycles allowed after the last expected result for stray results to show up.
    localparam int TAIL_CYCLES = 20;

    // The scoreboard keeps its own copy of the parser state. Every accepted byte is run
    // through the predictor, which appends the results it causes to the expected queue.
    // Every accepted result is then compared with the oldest entry of that queue.
    class vt_result_board;
        parse_state_t parse_st;
        bit           dle_in_frame;
        logic [15:0]  first_param;
        logic [15:0]  second_param;
        logic [7:0]   params_seen;
        logic [3:0]   inters_seen;
        logic [5:0]   leader_code;
        logic [7:0]   frame_bytes [TEXT_DEPTH];
        logic [5:0]   frame_len;
        bit           frame_overflow;
        result_t      expected_q[$];
        int           bytes_noted;
        int           results_checked;
        int           mismatches;
        int           kind_hits [8];
        int           error_state_hits [8];
        int           overflow_frames;

        function new();
            parse_st = PS_GROUND;
            dle_in_frame = 1'b0;
            clear_csi();
            frame_len = '0;
            frame_overflow = 1'b0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Appends one predicted result at the tail of the expected queue.
        function void add_expected(result_t r);
            expected_q.insert(expected_q.size(), r);
        endfunction

        function void clear_csi();
            first_param = '0;
            second_param = '0;
            params_seen = '0;
            inters_seen = '0;
            leader_code = '0;
        endfunction

        function result_t make_result(logic [2:0] k, logic [7:0] v);
            result_t r;
            r = '0;
            r.kind = k;
            r.value = v;
            r.last = 1'b1;
            return r;
        endfunction

        function void open_param();
            if (params_seen != 8'hFF)
                params_seen++;
        endfunction

        function void count_inter();
            if (inters_seen != 4'hF)
                inters_seen++;
        endfunction

        // Decimal accumulation that sticks at the top of the 16-bit range.
        function logic [15:0] append_digit(logic [15:0] p, logic [7:0] c);
            int unsigned grown;
            grown = 32'(p) * 10 + 32'(c - CH_DIGIT_LO);
            return (grown > 32'hFFFF) ? 16'hFFFF : grown[15:0];
        endfunction

        function void take_digit(logic [7:0] c);
            if (params_seen == 8'd1)
                first_param = append_digit(first_param, c);
            else if (params_seen == 8'd2)
                second_param = append_digit(second_param, c);
        endfunction

        function void raise_error(logic [7:0] c);
            result_t r;
            r = make_result(KIND_ERROR, c);
            r.state_code = parse_st;
            add_expected(r);
            parse_st = PS_GROUND;
        endfunction

        function void close_csi(logic [7:0] c);
            result_t r;
            parse_st = PS_GROUND;
            if (params_seen == 8'd0)
                params_seen = 8'd1;
            if (c >= CH_ARROW_LO && c <= CH_ARROW_HI)
            begin
                add_expected(make_result(KIND_ARROW, c - CH_ARROW_LO));
            end
            else
            begin
                r = make_result(KIND_CSI, c);
                r.param_first = first_param;
                r.param_second = second_param;
                r.param_count = params_seen;
                r.inter_count = inters_seen;
                r.leader = leader_code;
                add_expected(r);
            end
        endfunction

        function bit is_digit(logic [7:0] c);
            return c >= CH_DIGIT_LO && c <= CH_DIGIT_HI;
        endfunction

        function bit is_inter(logic [7:0] c);
            return c >= CH_INTER_LO && c <= CH_INTER_HI;
        endfunction

        // Notes one accepted byte and predicts the results it causes.
        function void note_byte(logic [7:0] c);
            result_t r;
            bytes_noted++;
            case (parse_st)
                PS_ESC:
                begin
                    if (c == CH_LBRACKET)
                    begin
                        parse_st = PS_ENTRY;
                        clear_csi();
                    end
                    else if (c >= CH_DIGIT_LO && c <= CH_DEL)
                    begin
                        parse_st = PS_GROUND;
                    end
                    else
                    begin
                        raise_error(c);
                    end
                end
                PS_ENTRY:
                begin
                    if (c >= CH_LEAD_LO && c <= CH_LEAD_HI)
                    begin
                        leader_code = c[5:0];
                        open_param();
                        parse_st = PS_PARAM;
                    end
                    else if (is_digit(c))
                    begin
                        parse_st = PS_PARAM;
                        open_param();
                        take_digit(c);
                    end
                    else if (is_inter(c))
                    begin
                        parse_st = PS_INTER;
                        count_inter();
                    end
                    else if (c >= CH_FINAL_LO && c <= CH_DEL)
                    begin
                        close_csi(c);
                    end
                    else
                    begin
                        raise_error(c);
                    end
                end
                PS_PARAM:
                begin
                    if (is_digit(c))
                    begin
                        take_digit(c);
                    end
                    else if (c == CH_SEMI)
                    begin
                        open_param();
                    end
                    else if (is_inter(c))
                    begin
                        parse_st = PS_INTER;
                        count_inter();
                    end
                    else if (c >= CH_FINAL_LO && c <= CH_FINAL_HI)
                    begin
                        close_csi(c);
                    end
                    else
                    begin
                        raise_error(c);
                    end
                end
                PS_INTER:
                begin
                    if (is_inter(c))
                        count_inter();
                    else if (c >= CH_FINAL_LO && c <= CH_FINAL_HI)
                        close_csi(c);
                    else
                        raise_error(c);
                end
                PS_DLE:
                begin
                    if (c == CH_STX && !dle_in_frame)
                    begin
                        frame_len = '0;
                        frame_overflow = 1'b0;
                        parse_st = PS_TEXT;
                    end
                    else if (c == CH_ETX && dle_in_frame)
                    begin
                        parse_st = PS_GROUND;
                        for (int i = 0; i < frame_len; i++)
                        begin
                            r = make_result(KIND_TEXT, frame_bytes[i]);
                            r.last = 1'b0;
                            add_expected(r);
                        end
                        r = make_result(KIND_TEXT_END, '0);
                        r.overflow = frame_overflow;
                        add_expected(r);
                    end
                    else
                    begin
                        raise_error(c);
                    end
                end
                PS_TEXT:
                begin
                    if (c == CH_DLE)
                    begin
                        dle_in_frame = 1'b1;
                        parse_st = PS_DLE;
                    end
                    else if (frame_len < TEXT_DEPTH)
                    begin
                        frame_bytes[frame_len[FRAME_AW-1:0]] = c;
                        frame_len++;
                    end
                    else
                    begin
                        frame_overflow = 1'b1;
                    end
                end
                default:
                begin
                    if (c == CH_ESC)
                    begin
                        parse_st = PS_ESC;
                    end
                    else if (c == CH_CSI)
                    begin
                        parse_st = PS_ENTRY;
                        clear_csi();
                    end
                    else if (c == CH_DLE)
                    begin
                        dle_in_frame = 1'b0;
                        parse_st = PS_DLE;
                    end
                    else
                    begin
                        add_expected(make_result(KIND_CHAR, c));
                    end
                end
            endcase
        endfunction

        task report_mismatch(string what, logic [15:0] got_v, logic [15:0] want_v);
            mismatches++;
            $display("[%0t] result %0d: %s is 0x%0h, expected 0x%0h",
                     $realtime, results_checked, what, got_v, want_v);
        endtask

        // Compares one accepted result, field by field, with the oldest expectation.
        task check_result(result_t got);
            result_t want;
            if (expected_q.size() == 0)
            begin
                report_mismatch("unexpected result of kind", 16'(got.kind), '0);
                return;
            end
            want = expected_q.pop_front();
            results_checked++;
            kind_hits[want.kind]++;
            if (want.kind == KIND_ERROR)
                error_state_hits[want.state_code]++;
            if (want.kind == KIND_TEXT_END && want.overflow)
                overflow_frames++;
            if (got.kind !== want.kind)
                report_mismatch("kind", 16'(got.kind), 16'(want.kind));
            if (got.value !== want.value)
                report_mismatch("value", 16'(got.value), 16'(want.value));
            if (got.param_first !== want.param_first)
                report_mismatch("param_first", got.param_first, want.param_first);
            if (got.param_second !== want.param_second)
                report_mismatch("param_second", got.param_second, want.param_second);
            if (got.param_count !== want.param_count)
                report_mismatch("param_count", 16'(got.param_count), 16'(want.param_count));
            if (got.inter_count !== want.inter_count)
                report_mismatch("inter_count", 16'(got.inter_count), 16'(want.inter_count));
            if (got.leader !== want.leader)
                report_mismatch("leader", 16'(got.leader), 16'(want.leader));
            if (got.state_code !== want.state_code)
                report_mismatch("state_code", 16'(got.state_code), 16'(want.state_code));
            if (got.overflow !== want.overflow)
                report_mismatch("overflow", 16'(got.overflow), 16'(want.overflow));
            if (got.last !== want.last)
                report_mismatch("last", 16'(got.last), 16'(want.last));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  kind;
    logic [7:0]  value;
    logic [15:0] param_first;
    logic [15:0] param_second;
    logic [7:0]  param_count;
    logic [3:0]  inter_count;
    logic [5:0]  leader;
    logic [2:0]  state_code;
    logic        overflow;
    logic        last;

    vt_result_board board;
    logic [7:0]     stim_q[$];
    int             cycle_count = 0;

    vt_escape_sequence_parser_core #(
        .TEXT_DEPTH(TEXT_DEPTH)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .rx_byte(rx_byte),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .kind(kind),
        .value(value),
        .param_first(param_first),
        .param_second(param_second),
        .param_count(param_count),
        .inter_count(inter_count),
        .leader(leader),
        .state_code(state_code),
        .overflow(overflow),
        .last(last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // The watchdog ends a run that hangs, for instance when a result never arrives.
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("Run timed out after %0d cycles with %0d results still expected.",
                 cycle_count, board.pending());
        $display("FAILURE");
        $finish;
    end

    // Both channels are sampled at the rising edge, where every input driven by this
    // testbench still holds its value from before the edge. Results are checked before
    // the byte of the same edge is noted; a result never depends on a byte accepted at
    // the same edge, since the output is registered.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                board.check_result({kind, value, param_first, param_second, param_count,
                                    inter_count, leader, state_code, overflow, last});
            if (in_valid && in_ready)
                board.note_byte(rx_byte);
        end
    end

    // The receiver switches between stall patterns of random length: always ready,
    // coin flip, mostly ready and mostly stalled. Once, after enough bytes have gone in,
    // it holds off for a long stretch so that the output register stays full and the
    // parser has to stall its input while the sender keeps offering bytes.
    initial
    begin : receiver
        int  mode;
        int  phase_left;
        int  held;
        bit  long_hold_done;
        mode = 0;
        phase_left = 0;
        long_hold_done = 1'b0;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (!long_hold_done && board.bytes_noted >= LONG_HOLD_AFTER)
            begin
                out_ready <= 1'b0;
                held = 0;
                while (held < LONG_HOLD_CYCLES)
                begin
                    @(posedge clk);
                    held++;
                end
                long_hold_done = 1'b1;
            end
            if (phase_left == 0)
            begin
                mode = $urandom_range(3, 0);
                phase_left = $urandom_range(60, 10);
            end
            phase_left--;
            case (mode)
                0: out_ready <= 1'b1;
                1: out_ready <= $urandom_range(1, 0) == 1;
                2: out_ready <= $urandom_range(3, 0) != 0;
                default: out_ready <= $urandom_range(3, 0) == 0;
            endcase
        end
    end

    // Appends one byte at the tail of the stimulus queue.
    function automatic void add_stim(logic [7:0] b);
        stim_q.insert(stim_q.size(), b);
    endfunction

    // Offers one byte and returns at the edge where it is transferred. It is called at
    // a rising edge, and valid stays high with the byte unchanged until the transfer.
    task automatic send_byte(input logic [7:0] b);
        in_valid <= 1'b1;
        rx_byte <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Sends everything that is queued, in bursts of random length with random gaps.
    // Now and then a long burst keeps valid high with no gap at all.
    task automatic send_all();
        int burst;
        int gap;
        while (stim_q.size() > 0)
        begin
            burst = ($urandom_range(5, 0) == 0) ? $urandom_range(40, 15)
                                                : $urandom_range(6, 1);
            while (burst > 0 && stim_q.size() > 0)
            begin
                send_byte(stim_q.pop_front());
                burst--;
            end
            if (stim_q.size() > 0)
            begin
                gap = $urandom_range(4, 0);
                if (gap > 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
        in_valid <= 1'b0;
    endtask

    // Holds the sender until every expected result has been transferred. The first edge
    // lets the byte transferred at the calling edge reach the predictor.
    task automatic wait_for_results();
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] pick(logic [7:0] lo, logic [7:0] hi);
        return lo + 8'($urandom_range(int'(hi - lo), 0));
    endfunction

    // A CSI sequence with random content: either introducer, an optional private
    // leader, a few parameters (some long enough to saturate), optional intermediates
    // and a final byte that is often an arrow key. One in ten gets a stray byte
    // before the final, which usually turns it into an error.
    function automatic void queue_csi();
        int  n_params;
        int  n_digits;
        int  n_inter;
        bit  has_leader;
        if ($urandom_range(1, 0) == 1)
        begin
            add_stim(CH_ESC);
            add_stim(CH_LBRACKET);
        end
        else
        begin
            add_stim(CH_CSI);
        end
        has_leader = $urandom_range(3, 0) == 0;
        if (has_leader)
            add_stim(pick(CH_LEAD_LO, CH_LEAD_HI));
        n_params = ($urandom_range(9, 0) == 0) ? $urandom_range(6, 4)
                                               : $urandom_range(3, 0);
        for (int p = 0; p < n_params; p++)
        begin
            if (p > 0)
                add_stim(CH_SEMI);
            if ($urandom_range(7, 0) == 0)
                n_digits = $urandom_range(8, 5);
            else
                n_digits = $urandom_range(3, (p == 0 && !has_leader) ? 1 : 0);
            repeat (n_digits)
                add_stim(pick(CH_DIGIT_LO, CH_DIGIT_HI));
        end
        n_inter = ($urandom_range(3, 0) == 0) ? $urandom_range(3, 1) : 0;
        repeat (n_inter)
            add_stim(pick(CH_INTER_LO, CH_INTER_HI));
        if ($urandom_range(9, 0) == 0)
            add_stim(8'($urandom_range(255, 0)));
        if ($urandom_range(9, 0) < 4)
            add_stim(pick(CH_ARROW_LO, CH_ARROW_HI));
        else
            add_stim(pick(CH_FINAL_LO, CH_FINAL_HI));
    endfunction

    // A text frame of the given length. A DLE in the body would end the frame early,
    // so it is swapped for another byte. One in eight frames is closed badly.
    function automatic void queue_frame(int n_bytes);
        logic [7:0] b;
        add_stim(CH_DLE);
        add_stim(CH_STX);
        repeat (n_bytes)
        begin
            b = 8'($urandom_range(255, 0));
            add_stim((b == CH_DLE) ? ~b : b);
        end
        add_stim(CH_DLE);
        add_stim(($urandom_range(7, 0) == 0) ? 8'($urandom_range(255, 0)) : CH_ETX);
    endfunction

    // Broken input: a lone byte, or an introducer followed by any byte at all.
    function automatic void queue_noise();
        case ($urandom_range(3, 0))
            0: ;
            1: add_stim(CH_ESC);
            2: add_stim(CH_DLE);
            default: add_stim(CH_CSI);
        endcase
        add_stim(8'($urandom_range(255, 0)));
    endfunction

    // Mostly well-formed sequences with random content; the rest plain bytes and noise.
    function automatic void queue_random(int target);
        int roll;
        while (stim_q.size() < target)
        begin
            roll = $urandom_range(99, 0);
            if (roll < 25)
            begin
                add_stim(8'($urandom_range(255, 0)));
            end
            else if (roll < 60)
            begin
                queue_csi();
            end
            else if (roll < 68)
            begin
                add_stim(CH_ESC);
                add_stim(pick(CH_DIGIT_LO, CH_DEL));
            end
            else if (roll < 83)
            begin
                queue_frame(($urandom_range(9, 0) == 0) ? $urandom_range(40, 30)
                                                        : $urandom_range(8, 0));
            end
            else
            begin
                queue_noise();
            end
        end
    endfunction

    initial
    begin : stimulus
        board = new();
        in_valid = 1'b0;
        rx_byte = '0;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Byte extremes pass through as characters, then an arrow key
        // by ESC [, then a CSI with a private leader, a saturating first parameter, an
        // empty second one, a third that is only counted, an intermediate and a final.
        stim_q = {8'h00, 8'hFF, CH_ESC, CH_LBRACKET, CH_ARROW_HI,
                  CH_CSI, CH_LEAD_HI, CH_DIGIT_LO + 8'd7, CH_DIGIT_LO, CH_DIGIT_LO,
                  CH_DIGIT_LO, CH_DIGIT_LO, CH_SEMI, CH_SEMI, CH_DIGIT_LO + 8'd5,
                  CH_INTER_LO + 8'd1, 8'h70};
        // A control byte after ESC is an error; DEL right after the CSI introducer is a
        // final with no parameter; a one-byte text frame is read back.
        add_stim(CH_ESC);
        add_stim(8'h00);
        add_stim(CH_CSI);
        add_stim(CH_DEL);
        add_stim(CH_DLE);
        add_stim(CH_STX);
        add_stim(8'h78);
        add_stim(CH_DLE);
        add_stim(CH_ETX);
        send_all();
        wait_for_results();

        // First random half, with one frame that fills the buffer exactly and one that
        // overflows it.
        queue_frame(TEXT_DEPTH);
        queue_random(60);
        queue_frame(TEXT_DEPTH + 4);
        queue_random(105);
        send_all();
        wait_for_results();

        // Second random half. It carries one crowded CSI with a dozen empty parameters
        // that drives the intermediate count into saturation, ended by the top final byte.
        queue_random(15);
        add_stim(CH_CSI);
        add_stim(CH_DIGIT_LO + 8'd1);
        repeat (12) add_stim(CH_SEMI);
        repeat (17) add_stim(pick(CH_INTER_LO, CH_INTER_HI));
        add_stim(CH_FINAL_HI);
        queue_frame(TEXT_DEPTH + 9);
        queue_random(stim_q.size() + 10);
        send_all();
        wait_for_results();

        // Let a few more cycles pass so that a stray result would still be caught.
        repeat (TAIL_CYCLES) @(posedge clk);

        $write("Covered %0d bytes, %0d results: %0d chars, %0d arrows, %0d CSI reports, ",
               board.bytes_noted, board.results_checked, board.kind_hits[KIND_CHAR],
               board.kind_hits[KIND_ARROW], board.kind_hits[KIND_CSI]);
        $display("%0d errors, %0d text bytes, %0d frame ends (%0d overflowed).",
                 board.kind_hits[KIND_ERROR], board.kind_hits[KIND_TEXT],
                 board.kind_hits[KIND_TEXT_END], board.overflow_frames);
        $write("Errors by parser state, ground to text: %0d %0d %0d %0d ",
               board.error_state_hits[PS_GROUND], board.error_state_hits[PS_ESC],
               board.error_state_hits[PS_ENTRY], board.error_state_hits[PS_PARAM]);
        $display("%0d %0d %0d; mismatches: %0d.",
                 board.error_state_hits[PS_INTER], board.error_state_hits[PS_DLE],
                 board.error_state_hits[PS_TEXT], board.mismatches);
        if (board.mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
